// ----- rtl/gajt_pkg.sv -----
// Shared types and constants for the grid maze search block.
`default_nettype none
package gajt_pkg;
   localparam int GRID_SIDE_DEF  = 10;
   localparam int NODE_COUNT_DEF = 100;
   localparam int OPEN_DEPTH_DEF = 128;
   localparam int MAX_RESULTS    = 64;
   localparam int NODE_W         = 7;

   typedef struct packed {
      logic [6:0] node_a;
      logic [6:0] node_b;
      logic       last_edge;
   } req_type;

   typedef struct packed {
      logic signed [1:0] turn;
      logic              turn_present;
      logic              goal_reached;
      logic              last_turn;
   } rsp_type;

   // direction bits of a neighbor mask
   localparam logic [1:0] DIR_EAST  = 2'd0;
   localparam logic [1:0] DIR_WEST  = 2'd1;
   localparam logic [1:0] DIR_SOUTH = 2'd2;
   localparam logic [1:0] DIR_NORTH = 2'd3;

   // angle classes: (-pi,0), zero, (0,pi), pi
   localparam logic [1:0] ANG_NEG  = 2'd0;
   localparam logic [1:0] ANG_ZERO = 2'd1;
   localparam logic [1:0] ANG_POS  = 2'd2;
   localparam logic [1:0] ANG_PI   = 2'd3;

   function automatic logic [1:0] angle_class(input logic signed [5:0] x,
                                              input logic signed [5:0] y);
      logic [1:0] c;
      if (y < 0) c = ANG_NEG;
      else if (y == 0 && x >= 0) c = ANG_ZERO;
      else if (y > 0) c = ANG_POS;
      else c = ANG_PI;
      return c;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/gajt_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module gajt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/grid_astar_junction_turns_top.sv -----
// Top level: edge loader, A* search over memories, path rebuild and turn output.
//
//  channel | dir | payload         | beat
//  req_    | in  | gajt_pkg::req_type | one maze edge
//  rsp_    | out | gajt_pkg::rsp_type | one junction turn sign
//
// A grid edge is taken in S_LOAD (accept and read), S_LOAD_B (update one
// end) and S_LOAD_W (update the other); an ignored edge in S_LOAD alone.
// The search pops the open list by a linear scan of its memory, one entry a
// cycle, then refills the hole in S_POP_W and S_POP_MV, and expands a
// present neighbor in S_NB_RD, S_NB_W and S_NB_UPD, an absent one in S_NB_RD
// alone. Rebuild visits S_BT_RD and S_BT_W per path cell and the junction
// scan S_SC_RD, S_SC_W and S_SC_EVAL. After a run a clearing pass resets the
// cost, predecessor and neighbor memories; no edge is taken then. After reset
// the same clearing pass runs first. A stalled rsp_ holds the run.
`default_nettype none
module grid_astar_junction_turns_top #(
   parameter int GRID_SIDE  = gajt_pkg::GRID_SIDE_DEF,
   parameter int NODE_COUNT = gajt_pkg::NODE_COUNT_DEF,
   parameter int OPEN_DEPTH = gajt_pkg::OPEN_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire gajt_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      gajt_pkg::rsp_type rsp_data
);
   localparam int NW = $clog2(NODE_COUNT + 1);
   localparam int OW = $clog2(OPEN_DEPTH);
   localparam int CW = $clog2(OPEN_DEPTH + 1);
   localparam int PD = NODE_COUNT + 2;
   localparam int PW = $clog2(PD);
   localparam int GW = 8;                       // cost width, costs < 256
   localparam logic [GW-1:0] INF = '1;
   localparam logic [NW-1:0] NONE = '1;
   localparam logic [NW-1:0] GOAL = NW'(NODE_COUNT - 1);
   localparam int FW = GW + 1;

   typedef enum logic [20:0] {
      S_CLEAR   = 21'h000001,
      S_LOAD    = 21'h000002,
      S_LOAD_B  = 21'h000004,
      S_LOAD_W  = 21'h000008,
      S_START   = 21'h000010,
      S_POP     = 21'h000020,
      S_POP_W   = 21'h000040,
      S_POP_MV  = 21'h000080,
      S_EXP_RD  = 21'h000100,
      S_EXP_W   = 21'h000200,
      S_NB_RD   = 21'h000400,
      S_NB_W    = 21'h000800,
      S_NB_UPD  = 21'h001000,
      S_BT_RD   = 21'h002000,
      S_BT_W    = 21'h004000,
      S_SC_RD   = 21'h008000,
      S_SC_W    = 21'h010000,
      S_SC_EVAL = 21'h020000,
      S_OUT     = 21'h040000,
      S_POP_RD  = 21'h080000,
      S_DONE    = 21'h100000
   } state_type;

   state_type state_ff, state_in;

   // memories
   logic          nb_we;   logic [NW-1:0] nb_wa, nb_ra; logic [3:0]    nb_wd, nb_rd;
   logic          g_we;    logic [NW-1:0] g_wa, g_ra;   logic [GW-1:0] g_wd, g_rd;
   logic          p_we;    logic [NW-1:0] p_wa, p_ra;   logic [NW-1:0] p_wd, p_rd;
   logic          o_we;    logic [OW-1:0] o_wa, o_ra;
   logic [FW+NW-1:0] o_wd, o_rd;
   logic          b_we;    logic [PW-1:0] b_wa, b_ra;   logic [NW:0]   b_wd, b_rd;

   gajt_ram #(.WIDTH(4),     .DEPTH(NODE_COUNT)) u_nb (.clock, .wr_en(nb_we),
      .wr_addr(nb_wa), .wr_data(nb_wd), .rd_addr(nb_ra), .rd_data(nb_rd));
   gajt_ram #(.WIDTH(GW),    .DEPTH(NODE_COUNT)) u_g  (.clock, .wr_en(g_we),
      .wr_addr(g_wa), .wr_data(g_wd), .rd_addr(g_ra), .rd_data(g_rd));
   gajt_ram #(.WIDTH(NW),    .DEPTH(NODE_COUNT)) u_p  (.clock, .wr_en(p_we),
      .wr_addr(p_wa), .wr_data(p_wd), .rd_addr(p_ra), .rd_data(p_rd));
   gajt_ram #(.WIDTH(FW+NW), .DEPTH(OPEN_DEPTH)) u_o  (.clock, .wr_en(o_we),
      .wr_addr(o_wa), .wr_data(o_wd), .rd_addr(o_ra), .rd_data(o_rd));
   gajt_ram #(.WIDTH(NW+1),  .DEPTH(PD))         u_b  (.clock, .wr_en(b_we),
      .wr_addr(b_wa), .wr_data(b_wd), .rd_addr(b_ra), .rd_data(b_rd));

   // registers
   logic [NW-1:0] clr_ff, clr_in;
   logic [NW-1:0] ea_ff, ea_in, eb_ff, eb_in;
   logic [1:0]    ed_ff, ed_in;
   logic          elast_ff, elast_in;
   logic [CW-1:0] ocnt_ff, ocnt_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [OW-1:0] best_ff, best_in;
   logic [FW+NW-1:0] bestv_ff, bestv_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [3:0]    cmask_ff, cmask_in;
   logic [GW-1:0] cg_ff, cg_in;
   logic [2:0]    dir_ff, dir_in;
   logic [NW-1:0] nbn_ff, nbn_in;
   logic          reached_ff, reached_in;
   logic [PW-1:0] plen_ff, plen_in;       // cells pushed into buffer (reversed)
   logic [PW-1:0] si_ff, si_in;           // scan index
   logic [NW:0]   w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic signed [1:0] pturn_ff, pturn_in;
   logic          rv_ff, rv_in;
   gajt_pkg::rsp_type rd_ff, rd_in;

   // column and row of a cell index, as constant lookup tables
   function automatic int col_of(input logic [NW-1:0] n);
      int c;
      c = 0;
      for (int i = 0; i <= NODE_COUNT; i++) if (32'(n) == i) c = i % GRID_SIDE;
      return c;
   endfunction

   function automatic int row_of(input logic [NW-1:0] n);
      int r;
      r = 0;
      for (int i = 0; i <= NODE_COUNT; i++) if (32'(n) == i) r = i / GRID_SIDE;
      return r;
   endfunction

   // grid helpers
   function automatic logic [NW-1:0] nbr(input logic [NW-1:0] n, input logic [1:0] d,
                                          output logic ok);
      logic [NW-1:0] r;
      r = '0; ok = 1'b0;
      case (d)
         gajt_pkg::DIR_EAST: begin
            ok = (col_of(n) != GRID_SIDE - 1) && (32'(n) + 1 < NODE_COUNT);
            r = n + NW'(1);
         end
         gajt_pkg::DIR_WEST: begin
            ok = (col_of(n) != 0);
            r = n - NW'(1);
         end
         gajt_pkg::DIR_SOUTH: begin
            ok = (32'(n) + GRID_SIDE < NODE_COUNT);
            r = NW'(32'(n) + GRID_SIDE);
         end
         default: begin
            ok = (32'(n) >= GRID_SIDE);
            r = NW'(32'(n) - GRID_SIDE);
         end
      endcase
      return r;
   endfunction

   function automatic logic [GW-1:0] heur(input logic [NW-1:0] n);
      int ax, ay, bx, by, dx, dy;
      ax = col_of(n); ay = row_of(n);
      bx = (NODE_COUNT - 1) % GRID_SIDE; by = (NODE_COUNT - 1) / GRID_SIDE;
      dx = ax > bx ? ax - bx : bx - ax;
      dy = ay > by ? ay - by : by - ay;
      return GW'(dx + dy);
   endfunction

   // coordinates of a path word: top bit marks entry, node NODE_COUNT marks exit
   function automatic void coord(input logic [NW:0] v, output logic signed [5:0] x,
                                 output logic signed [5:0] y);
      if (v[NW]) begin x = -6'sd1; y = 6'sd0; end
      else begin
         x = 6'(col_of(v[NW-1:0]));
         y = 6'(row_of(v[NW-1:0]));
      end
   endfunction

   function automatic logic signed [1:0] turn_of(input logic [NW:0] p,
                                                 input logic [NW:0] c,
                                                 input logic [NW:0] q);
      logic signed [5:0] px, py, cx, cy, qx, qy, nx, ny, bx, by;
      logic signed [12:0] cr;
      logic [1:0] cn, cb;
      logic signed [1:0] t;
      coord(p, px, py); coord(c, cx, cy); coord(q, qx, qy);
      nx = qx - px; ny = qy - py; bx = cx - px; by = cy - py;
      cn = gajt_pkg::angle_class(nx, ny);
      cb = gajt_pkg::angle_class(bx, by);
      cr = 13'(bx) * 13'(ny) - 13'(by) * 13'(nx);
      if (cn != cb) t = (cn > cb) ? 2'sd1 : -2'sd1;
      else if (cn == gajt_pkg::ANG_ZERO || cn == gajt_pkg::ANG_PI) t = 2'sd0;
      else t = (cr > 0) ? 2'sd1 : ((cr < 0) ? -2'sd1 : 2'sd0);
      return t;
   endfunction

   logic nok;
   logic [NW-1:0] nnode;
   logic [FW-1:0] of_c, of_b;
   logic [NW-1:0] on_c, on_b;
   logic [2:0]    deg;
   logic [NW:0]   exit_w;

   always_comb begin
      nnode = nbr(cur_ff, dir_ff[1:0], nok);
      of_c = o_rd[FW+NW-1:NW]; on_c = o_rd[NW-1:0];
      of_b = bestv_ff[FW+NW-1:NW]; on_b = bestv_ff[NW-1:0];
      deg = 3'(nb_rd[0]) + 3'(nb_rd[1]) + 3'(nb_rd[2]) + 3'(nb_rd[3])
          + 3'(w1_ff[NW-1:0] == '0) + 3'(w1_ff[NW-1:0] == GOAL);
      exit_w = {1'b0, NW'(NODE_COUNT)};
   end

   // sequencer
   always_comb begin
      logic okab;
      state_in = state_ff;
      clr_in = clr_ff; ea_in = ea_ff; eb_in = eb_ff; ed_in = ed_ff; elast_in = elast_ff;
      ocnt_in = ocnt_ff; scan_in = scan_ff; best_in = best_ff; bestv_in = bestv_ff;
      cur_in = cur_ff; cmask_in = cmask_ff; cg_in = cg_ff; dir_in = dir_ff;
      nbn_in = nbn_ff; reached_in = reached_ff; plen_in = plen_ff; si_in = si_ff;
      w0_in = w0_ff; w1_in = w1_ff; w2_in = w2_ff; cnt_in = cnt_ff;
      pend_in = pend_ff; pturn_in = pturn_ff; rv_in = rv_ff; rd_in = rd_ff;
      nb_we = 1'b0; nb_wa = '0; nb_wd = '0; nb_ra = '0;
      g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
      o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
      b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
      req_ready = 1'b0;
      okab = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      case (state_ff)
         // sweep the node memories back to reset values
         S_CLEAR: begin
            nb_we = 1'b1; nb_wa = clr_ff; nb_wd = '0;
            g_we = 1'b1; g_wa = clr_ff; g_wd = INF;
            p_we = 1'b1; p_wa = clr_ff; p_wd = NONE;
            clr_in = clr_ff + NW'(1);
            if (32'(clr_ff) == NODE_COUNT - 1) begin
               clr_in = '0; state_in = S_LOAD;
            end
         end
         // take an edge; find its direction
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ea_in = NW'(req_data.node_a); eb_in = NW'(req_data.node_b);
               elast_in = req_data.last_edge;
               okab = 1'b0;
               for (int d = 0; d < 4; d++) begin
                  logic ok1;
                  logic [NW-1:0] nn;
                  nn = nbr(NW'(req_data.node_a), 2'(d), ok1);
                  if (ok1 && 32'(req_data.node_a) < NODE_COUNT
                      && 32'(req_data.node_b) < NODE_COUNT && nn == NW'(req_data.node_b)) begin
                     okab = 1'b1; ed_in = 2'(d);
                  end
               end
               nb_ra = NW'(req_data.node_a);
               if (okab) state_in = S_LOAD_B;
               else if (req_data.last_edge) state_in = S_START;
            end
         end
         S_LOAD_B: begin
            nb_we = 1'b1; nb_wa = ea_ff; nb_wd = nb_rd | (4'b1 << ed_ff);
            nb_ra = eb_ff;
            state_in = S_LOAD_W;
         end
         S_LOAD_W: begin
            nb_we = 1'b1; nb_wa = eb_ff; nb_wd = nb_rd | (4'b1 << (ed_ff ^ 2'd1));
            state_in = elast_ff ? S_START : S_LOAD;
         end
         // seed the open list with the start cell
         S_START: begin
            g_we = 1'b1; g_wa = '0; g_wd = '0;
            o_we = 1'b1; o_wa = '0; o_wd = {FW'(heur('0)), NW'(0)};
            ocnt_in = CW'(1); reached_in = 1'b0;
            state_in = S_POP_RD;
         end
         S_POP_RD: begin
            if (ocnt_ff == '0) begin
               state_in = S_BT_RD; cur_in = GOAL; plen_in = '0;
            end else begin
               o_ra = '0; scan_in = CW'(1); state_in = S_POP;
            end
         end
         // linear scan for the smallest (f, node)
         S_POP: begin
            if (scan_ff == CW'(1) || of_c < of_b || (of_c == of_b && on_c < on_b)) begin
               bestv_in = o_rd; best_in = OW'(scan_ff - CW'(1));
            end
            o_ra = OW'(scan_ff);
            scan_in = scan_ff + CW'(1);
            if (scan_ff == ocnt_ff) begin
               state_in = S_POP_W;
               o_ra = OW'(ocnt_ff - CW'(1));
            end
         end
         S_POP_W: begin
            // last entry now on o_rd; keep it there for the move
            o_ra = OW'(ocnt_ff - CW'(1));
            state_in = S_POP_MV;
         end
         S_POP_MV: begin
            o_we = 1'b1; o_wa = best_ff; o_wd = o_rd;
            ocnt_in = ocnt_ff - CW'(1);
            cur_in = on_b;
            if (on_b == GOAL) begin
               reached_in = 1'b1; state_in = S_BT_RD; cur_in = GOAL; plen_in = '0;
            end else begin
               nb_ra = on_b; g_ra = on_b; state_in = S_EXP_RD;
            end
         end
         S_EXP_RD: begin
            cmask_in = nb_rd; cg_in = g_rd; dir_in = '0; state_in = S_NB_RD;
         end
         // visit neighbors one direction at a time
         S_NB_RD: begin
            if (dir_ff[2]) state_in = S_POP_RD;
            else if (cmask_ff[dir_ff[1:0]] && nok) begin
               nbn_in = nnode; g_ra = nnode; state_in = S_NB_W;
            end else dir_in = dir_ff + 3'd1;
         end
         S_NB_W: begin
            state_in = S_NB_UPD;
            if (cg_ff + GW'(1) < g_rd) begin
               g_we = 1'b1; g_wa = nbn_ff; g_wd = cg_ff + GW'(1);
               p_we = 1'b1; p_wa = nbn_ff; p_wd = cur_ff;
               if (32'(ocnt_ff) < OPEN_DEPTH) begin
                  o_we = 1'b1; o_wa = OW'(ocnt_ff);
                  o_wd = {FW'(cg_ff) + FW'(1) + FW'(heur(nbn_ff)), nbn_ff};
                  ocnt_in = ocnt_ff + CW'(1);
               end
            end
         end
         S_NB_UPD: begin
            dir_in = dir_ff + 3'd1; state_in = S_NB_RD;
         end
         // walk predecessors back from the goal into the path buffer
         S_BT_RD: begin
            b_we = 1'b1; b_wa = plen_ff; b_wd = {1'b0, cur_ff};
            plen_in = plen_ff + PW'(1);
            p_ra = cur_ff; state_in = S_BT_W;
         end
         S_BT_W: begin
            if (p_rd == NONE || 32'(p_rd) >= NODE_COUNT || 32'(plen_ff) >= NODE_COUNT) begin
               // scan from buffer end (cell 0 side) toward goal
               si_in = plen_ff - PW'(1);
               w0_in = {1'b1, NW'(0)};
               cnt_in = '0; pend_in = 1'b0;
               b_ra = plen_ff - PW'(1);
               state_in = S_SC_RD;
            end else begin
               cur_in = p_rd; state_in = S_BT_RD;
            end
         end
         S_SC_RD: begin
            w1_in = b_rd; nb_ra = b_rd[NW-1:0];
            if (si_ff != '0) b_ra = si_ff - PW'(1);
            state_in = S_SC_W;
         end
         S_SC_W: begin
            w2_in = (si_ff == '0) ? exit_w : b_rd;
            nb_ra = w1_ff[NW-1:0];
            state_in = S_SC_EVAL;
         end
         // junction check and output
         S_SC_EVAL: begin
            nb_ra = w1_ff[NW-1:0];
            if (!pend_ff || !rv_ff || rsp_ready) begin
               if (deg > 3'd2 && cnt_ff < 7'(gajt_pkg::MAX_RESULTS)) begin
                  if (pend_ff) begin
                     rv_in = 1'b1;
                     rd_in = '{turn: pturn_ff, turn_present: 1'b1,
                               goal_reached: reached_ff, last_turn: 1'b0};
                  end
                  pend_in = 1'b1; pturn_in = turn_of(w0_ff, w1_ff, w2_ff);
                  cnt_in = cnt_ff + 7'd1;
               end
               w0_in = w1_ff;
               if (si_ff == '0) state_in = S_OUT;
               else begin
                  si_in = si_ff - PW'(1); b_ra = si_ff - PW'(1);
                  state_in = S_SC_RD;
               end
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               rd_in = '{turn: pend_ff ? pturn_ff : 2'sd0, turn_present: pend_ff,
                         goal_reached: reached_ff, last_turn: 1'b1};
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rv_ff || rsp_ready) begin clr_in = '0; state_in = S_CLEAR; end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; ocnt_ff <= '0; rv_ff <= 1'b0;
         pend_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; ocnt_ff <= ocnt_in; rv_ff <= rv_in;
         pend_ff <= pend_in; cnt_ff <= cnt_in;
      end
      ea_ff <= ea_in; eb_ff <= eb_in; ed_ff <= ed_in; elast_ff <= elast_in;
      scan_ff <= scan_in; best_ff <= best_in; bestv_ff <= bestv_in; cur_ff <= cur_in;
      cmask_ff <= cmask_in; cg_ff <= cg_in; dir_ff <= dir_in; nbn_ff <= nbn_in;
      reached_ff <= reached_in; plen_ff <= plen_in; si_ff <= si_in;
      w0_ff <= w0_in; w1_ff <= w1_in; w2_ff <= w2_in; pturn_ff <= pturn_in;
      rd_ff <= rd_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;
endmodule
`default_nettype wire

// ----- rtl/gajt_checker.sv -----
// Port-level checks for the maze search top level, bound to it.
`default_nettype none
module gajt_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire gajt_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire gajt_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");
   a_turn_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.turn != -2'sd2)
      else $error("turn out of range");
   a_absent_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.turn_present |-> rsp_data.last_turn && rsp_data.turn == 2'sd0)
      else $error("no-junction beat malformed");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("edge taken while results pending");
endmodule

bind grid_astar_junction_turns_top gajt_checker u_gajt_checker (.*);
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the grid maze search block: edge loading, search, junction turns.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   localparam int SIDE        = 10;
   localparam int NODES       = 100;
   localparam int OPEN_MAX    = 128;
   localparam int COST_NONE   = 32'h7fff_ffff;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_WAIT  = 300;
   localparam int HOLD_CYCLES = 5000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   gajt_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   gajt_pkg::rsp_type rsp_data;

   grid_astar_junction_turns_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // predictor copy of the block's stores
   int nbr_mask [NODES];
   int path_cost[NODES];
   int came_from[NODES];
   int open_f   [OPEN_MAX];
   int open_n   [OPEN_MAX];
   int open_cnt;

   gajt_pkg::rsp_type turn_q[$];
   gajt_pkg::req_type maze_q[$];
   int      errors;
   int      edges_sent;
   int      cycles;
   int      send_idle;
   int      recv_idle;
   bit      hold_req;
   int      hold_left;

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report(input string what);
      $display("mismatch @%0d: %s", cycles, what);
      errors++;
   endtask

   // ---------------- predictor ----------------
   function automatic int step_to(int n, int d);
      case (d)
         gajt_pkg::DIR_EAST:  return (n % SIDE != SIDE - 1 && n + 1 < NODES) ? n + 1 : -1;
         gajt_pkg::DIR_WEST:  return (n % SIDE != 0) ? n - 1 : -1;
         gajt_pkg::DIR_SOUTH: return (n + SIDE < NODES) ? n + SIDE : -1;
         default:             return (n >= SIDE) ? n - SIDE : -1;
      endcase
   endfunction

   function automatic int dist_to_goal(int n);
      int dx, dy;
      dx = (SIDE - 1) - n % SIDE;
      dy = (SIDE - 1) - n / SIDE;
      return (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
   endfunction

   function automatic int ang_class(int x, int y);
      if (y < 0) return 0;
      if (y == 0 && x >= 0) return 1;
      if (y > 0) return 2;
      return 3;
   endfunction

   // sign of angle(n) - angle(b)
   function automatic int turn_sign(int nx, int ny, int bx, int by);
      int cn, cb, cr;
      cn = ang_class(nx, ny);
      cb = ang_class(bx, by);
      if (cn != cb) return cn > cb ? 1 : -1;
      if (cn == 1 || cn == 3) return 0;
      cr = bx * ny - by * nx;
      return cr > 0 ? 1 : (cr < 0 ? -1 : 0);
   endfunction

   function automatic int junction_degree(int n);
      int c;
      c = 0;
      for (int d = 0; d < 4; d++) c += (nbr_mask[n] >> d) & 1;
      if (n == 0) c++;
      if (n == NODES - 1) c++;
      return c;
   endfunction

   function automatic void clear_maze();
      for (int i = 0; i < NODES; i++) begin
         nbr_mask[i]  = 0;
         path_cost[i] = COST_NONE;
         came_from[i] = -1;
      end
      open_cnt = 0;
   endfunction

   function automatic void push_open(int f, int n);
      if (open_cnt >= OPEN_MAX) return;
      open_f[open_cnt] = f;
      open_n[open_cnt] = n;
      open_cnt++;
   endfunction

   function automatic int pop_open();
      int best, n;
      best = 0;
      for (int i = 1; i < open_cnt; i++)
         if (open_f[i] < open_f[best] ||
             (open_f[i] == open_f[best] && open_n[i] < open_n[best]))
            best = i;
      n = open_n[best];
      open_cnt--;
      open_f[best] = open_f[open_cnt];
      open_n[best] = open_n[open_cnt];
      return n;
   endfunction

   function automatic bit search_goal();
      int cur, nb;
      path_cost[0] = 0;
      push_open(dist_to_goal(0), 0);
      while (open_cnt > 0) begin
         cur = pop_open();
         if (cur == NODES - 1) return 1'b1;
         for (int d = 0; d < 4; d++) begin
            if (((nbr_mask[cur] >> d) & 1) == 0) continue;
            nb = step_to(cur, d);
            if (nb < 0) continue;
            if (path_cost[cur] + 1 < path_cost[nb]) begin
               path_cost[nb] = path_cost[cur] + 1;
               came_from[nb] = cur;
               push_open(path_cost[nb] + dist_to_goal(nb), nb);
            end
         end
      end
      return 1'b0;
   endfunction

   // one accepted edge beat: load it, and on the final edge queue the turns
   function automatic void predict_turns(gajt_pkg::req_type r);
      int a, b, k, cur, t, cnt, len;
      int rev[NODES];
      int path[NODES + 2];
      int px, py, cx, cy, qx, qy;
      bit found;
      gajt_pkg::rsp_type e;
      a = r.node_a;
      b = r.node_b;
      if (a < NODES && b < NODES)
         for (int d = 0; d < 4; d++)
            if (step_to(a, d) == b) begin
               nbr_mask[a] |= 1 << d;
               nbr_mask[b] |= 1 << (d ^ 1);
            end
      if (!r.last_edge) return;
      found = search_goal();
      // walk back from the goal
      k = 0;
      cur = NODES - 1;
      while (k < NODES) begin
         rev[k++] = cur;
         if (came_from[cur] < 0) break;
         cur = came_from[cur];
      end
      len = 0;
      path[len++] = -1;
      while (k > 0) path[len++] = rev[--k];
      path[len++] = NODES;
      cnt = 0;
      for (int i = 1; i + 1 < len && cnt < gajt_pkg::MAX_RESULTS; i++) begin
         if (junction_degree(path[i]) <= 2) continue;
         px = path[i-1] < 0 ? -1 : path[i-1] % SIDE;
         py = path[i-1] < 0 ? 0  : path[i-1] / SIDE;
         cx = path[i] % SIDE;
         cy = path[i] / SIDE;
         qx = path[i+1] % SIDE;
         qy = path[i+1] / SIDE;
         t = turn_sign(qx - px, qy - py, cx - px, cy - py);
         e.turn         = t[1:0];
         e.turn_present = 1'b1;
         e.goal_reached = found;
         e.last_turn    = 1'b0;
         turn_q = {turn_q, e};
         cnt++;
      end
      if (cnt == 0) begin
         e = '0;
         e.goal_reached = found;
         turn_q = {turn_q, e};
      end
      turn_q[turn_q.size() - 1].last_turn = 1'b1;
      clear_maze();
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      gajt_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (turn_q.size() == 0) begin
            report($sformatf("unexpected turn beat %b", rsp_data));
         end else begin
            e = turn_q.pop_front();
            if (rsp_data.turn !== e.turn)
               report($sformatf("turn %0d, want %0d", rsp_data.turn, e.turn));
            if (rsp_data.turn_present !== e.turn_present)
               report($sformatf("turn_present %b, want %b",
                                rsp_data.turn_present, e.turn_present));
            if (rsp_data.goal_reached !== e.goal_reached)
               report($sformatf("goal_reached %b, want %b",
                                rsp_data.goal_reached, e.goal_reached));
            if (rsp_data.last_turn !== e.last_turn)
               report($sformatf("last_turn %b, want %b",
                                rsp_data.last_turn, e.last_turn));
         end
      end
   end

   // receiver: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // ---------------- stimulus ----------------
   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_edge(gajt_pkg::req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predict_turns(r);
      edges_sent++;
      @(negedge clock);
   endtask

   function automatic gajt_pkg::req_type mk(int a, int b, bit last);
      gajt_pkg::req_type r;
      r.node_a    = a[6:0];
      r.node_b    = b[6:0];
      r.last_edge = last;
      return r;
   endfunction

   task automatic send_maze();
      for (int i = 0; i < maze_q.size(); i++) begin
         if (i == maze_q.size() - 1) maze_q[i].last_edge = 1'b1;
         send_edge(maze_q[i]);
      end
      maze_q.delete();
   endtask

   // random staircase from 0 to the goal plus side edges and noise
   task automatic build_maze(int extras, bit broken);
      int x, y, n, m, d, cut, steps;
      gajt_pkg::req_type path_edges[$];
      x = 0; y = 0;
      while (!(x == SIDE - 1 && y == SIDE - 1)) begin
         n = y * SIDE + x;
         if (x < SIDE - 1 && (y == SIDE - 1 || $urandom_range(1))) x++;
         else y++;
         path_edges = {path_edges, mk(n, y * SIDE + x, 0)};
      end
      steps = path_edges.size();
      cut = broken ? $urandom_range(steps - 1) : -1;
      for (int i = 0; i < steps; i++) begin
         if (i == cut) continue;
         // some edges given in reverse order
         if ($urandom_range(1))
            path_edges[i] = mk(path_edges[i].node_b, path_edges[i].node_a, 0);
         maze_q = {maze_q, path_edges[i]};
      end
      for (int i = 0; i < extras; i++) begin
         case ($urandom_range(9))
            0: maze_q = {maze_q, mk($urandom_range(127), $urandom_range(127), 0)};
            1: if (maze_q.size() > 0)
                  maze_q = {maze_q, maze_q[$urandom_range(maze_q.size() - 1)]};
            default: begin
               n = $urandom_range(NODES - 1);
               d = $urandom_range(3);
               m = step_to(n, d);
               if (m >= 0) maze_q = {maze_q, mk(n, m, 0)};
            end
         endcase
      end
      // shuffle the queue so side edges land between path edges
      for (int i = 0; i < maze_q.size(); i++) begin
         gajt_pkg::req_type tmp;
         int j;
         j = $urandom_range(maze_q.size() - 1);
         tmp = maze_q[i]; maze_q[i] = maze_q[j]; maze_q[j] = tmp;
      end
   endtask

   // called at a falling edge; the request line goes idle while results drain
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (turn_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic test_directed();
      send_idle = 11; recv_idle = 64;
      // lone final edge: nothing loaded, goal unreachable, no junction
      send_edge(mk(0, 0, 1));
      // out-of-range cells and all-ones fields
      send_edge(mk(127, 127, 0));
      send_edge(mk(99, 100, 0));
      // row wrap is not a neighbor
      send_edge(mk(9, 10, 0));
      send_edge(mk(0, 1, 1));
      // corridor along row 0 then column 9 with stubs: straights and a right turn at the goal
      for (int i = 0; i < 9; i++) maze_q = {maze_q, mk(i, i + 1, 0)};
      for (int i = 0; i < 9; i++) maze_q = {maze_q, mk(i * 10 + 9, i * 10 + 19, 0)};
      maze_q = {maze_q, mk(3, 13, 0)};
      maze_q = {maze_q, mk(8, 7, 0)};
      maze_q = {maze_q, mk(19, 18, 0)};
      maze_q = {maze_q, mk(89, 88, 0)};
      maze_q = {maze_q, mk(98, 99, 0)};
      send_maze();
      wait_drained();
   endtask

   task automatic test_random(int target);
      int stop;
      stop = edges_sent + target;
      while (edges_sent < stop) begin
         build_maze($urandom_range(4, 24), $urandom_range(7) == 0);
         send_maze();
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle = 0; recv_idle = 0;
      build_maze(20, 0);
      send_maze();
      // receiver held off while the next maze is offered
      hold_req = 1'b1;
      build_maze(10, 0);
      send_maze();
      wait_drained();
   endtask

   initial begin
      errors = 0; edges_sent = 0; cycles = 0;
      hold_req = 1'b0; hold_left = 0;
      send_idle = 11; recv_idle = 64;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      clear_maze();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(35);
      send_idle = 64; recv_idle = 11;
      test_random(35);
      send_idle = 0; recv_idle = 0;
      test_random(35);
      test_backpressure();
      wait_drained();
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/gajt_pkg.sv
rtl/gajt_ram.sv
rtl/grid_astar_junction_turns_top.sv
rtl/gajt_checker.sv
tb/tb.sv
